### src/lcfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chain frame encoder package
// Shared widths, constants and the three-bit pulse coding of one colour byte.
// ----------------------------------------------------------------------------
package lcfe_pkg;

    localparam int MAX_LEDS_DEF   = 16;
    localparam int COLOURS        = 3;
    localparam int INDEX_W        = 4;
    localparam int COLOUR_W       = 8;
    localparam int ROW_W          = COLOURS * COLOUR_W;
    localparam int WORD_W         = 24;
    localparam int COUNT_W        = 5;
    localparam int ZB_W           = 5;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
    localparam logic [ZB_W-1:0]    GAP_BYTES   = 5'd18;

    // Symbols for one data bit on the SPI line.
    localparam logic [2:0] SYM_ONE  = 3'b110;
    localparam logic [2:0] SYM_ZERO = 3'b100;

    // Byte selector within one LED row.
    localparam logic [1:0] SEL_FIRST  = 2'd0;
    localparam logic [1:0] SEL_SECOND = 2'd1;
    localparam logic [1:0] SEL_THIRD  = 2'd2;

    function automatic logic [WORD_W-1:0] encode_byte(input logic [COLOUR_W-1:0] v);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int b = 0; b < COLOUR_W; b++) begin
            w[3*b +: 3] = v[b] ? SYM_ONE : SYM_ZERO;
        end
        return w;
    endfunction

endpackage

### src/lcfe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED chain frame encoder channels
// Valid/ready channels for LED colour writes and for encoded SPI words.
// ----------------------------------------------------------------------------
interface lcfe_in_if
    import lcfe_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [INDEX_W-1:0]  led_index;
    logic [COLOUR_W-1:0] first_color;
    logic [COLOUR_W-1:0] second_color;
    logic [COLOUR_W-1:0] third_color;

    modport source (output valid, led_index, first_color, second_color, third_color,
                    input ready);
    modport sink   (input valid, led_index, first_color, second_color, third_color,
                    output ready);
endinterface

interface lcfe_out_if
    import lcfe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] spi_word;
    logic [ZB_W-1:0]   zero_bytes;
    logic              index_error;
    logic              last;

    modport source (output valid, spi_word, zero_bytes, index_error, last,
                    input ready);
    modport sink   (input valid, spi_word, zero_bytes, index_error, last,
                    output ready);
endinterface

### src/lcfe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lcfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/led_chain_frame_encoder.sv
`timescale 1ns / 1ps
// The gap item is registered and valid in the cycle after an item is accepted.
// Each LED then takes one row read from the colour RAM (S_READ) followed by
// three encoded words (S_EMIT), one per colour byte, each waiting for a free output slot.
// A new item is accepted once the final word of the previous frame is loaded and
// the output slot is free. Reset (synchronous, active low) clears the row valid
// bits, so the store reads as all zero, and sets led_count to 16.
// ----------------------------------------------------------------------------
// LED chain frame encoder
// Stores per-LED colours and streams a full SPI-coded refresh frame per write.
// ----------------------------------------------------------------------------
module led_chain_frame_encoder
    import lcfe_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_wdata,
    lcfe_in_if.sink            i_in,
    lcfe_out_if.source         o_out
);
    localparam int LED_W = $clog2(MAX_LEDS > 1 ? MAX_LEDS : 2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_cfg_count;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [LED_W-1:0]   r_led, n_led;
    logic [1:0]         r_sel, n_sel;
    logic [MAX_LEDS-1:0] r_valid;

    logic               r_ov, n_ov;
    logic [WORD_W-1:0]  r_word, n_word;
    logic [ZB_W-1:0]    r_zb, n_zb;
    logic               r_err, n_err;
    logic               r_last, n_last;

    logic [COUNT_W-1:0] eff_count;
    logic               slot_free;
    logic               in_acc;
    logic               idx_ok;
    logic               ram_re;
    logic [ROW_W-1:0]   row_data;
    logic [COLOUR_W-1:0] cur_byte;
    logic               led_last;

    assign eff_count = (r_cfg_count > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS)
                                                          : r_cfg_count;
    assign slot_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && slot_free;
    assign in_acc    = i_in.valid && i_in.ready;
    assign idx_ok    = COUNT_W'(i_in.led_index) < eff_count;
    assign ram_re    = (r_state == S_READ);
    assign led_last  = (COUNT_W'(r_led) + COUNT_W'(1)) == r_cnt;

    lcfe_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && idx_ok),
        .i_waddr (LED_W'(i_in.led_index)),
        .i_wdata ({i_in.first_color, i_in.second_color, i_in.third_color}),
        .i_re    (ram_re),
        .i_raddr (r_led),
        .o_rdata (row_data)
    );

    // A row never written since reset reads as zero.
    always_comb begin
        case (r_sel)
            SEL_FIRST:  cur_byte = row_data[2*COLOUR_W +: COLOUR_W];
            SEL_SECOND: cur_byte = row_data[COLOUR_W +: COLOUR_W];
            default:    cur_byte = row_data[0 +: COLOUR_W];
        endcase
        if (!r_valid[r_led]) begin
            cur_byte = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_led   = r_led;
        n_sel   = r_sel;
        n_ov    = r_ov;
        n_word  = r_word;
        n_zb    = r_zb;
        n_err   = r_err;
        n_last  = r_last;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ov    = 1'b1;
                    n_word  = '0;
                    n_zb    = GAP_BYTES;
                    n_err   = !idx_ok;
                    n_last  = (eff_count == '0);
                    n_cnt   = eff_count;
                    n_led   = '0;
                    n_sel   = SEL_FIRST;
                    n_state = (eff_count == '0) ? S_IDLE : S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ov   = 1'b1;
                    n_word = encode_byte(cur_byte);
                    n_zb   = '0;
                    n_err  = 1'b0;
                    n_last = led_last && (r_sel == SEL_THIRD);
                    if (r_sel == SEL_THIRD) begin
                        n_sel = SEL_FIRST;
                        if (led_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_led   = r_led + LED_W'(1);
                            n_state = S_READ;
                        end
                    end else begin
                        n_sel = r_sel + 2'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ov        <= 1'b0;
            r_valid     <= '0;
            r_cfg_count <= COUNT_RESET;
            r_cnt       <= '0;
            r_led       <= '0;
            r_sel       <= SEL_FIRST;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
            r_led   <= n_led;
            r_sel   <= n_sel;
            if (i_cfg_we) begin
                r_cfg_count <= i_cfg_wdata;
            end
            if (in_acc && idx_ok) begin
                r_valid[LED_W'(i_in.led_index)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_zb   <= n_zb;
        r_err  <= n_err;
        r_last <= n_last;
    end

    assign o_out.valid       = r_ov;
    assign o_out.spi_word    = r_word;
    assign o_out.zero_bytes  = r_zb;
    assign o_out.index_error = r_err;
    assign o_out.last        = r_last;

    a_gap_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (o_out.valid && o_out.zero_bytes == GAP_BYTES))
        else $error("gap item did not follow an accepted item");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input ready while a frame is in progress");

    a_gap_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_zb != '0) |-> (r_word == '0))
        else $error("gap item carries a non-zero SPI word");

    a_err_only_on_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_zb == '0) |-> !r_err)
        else $error("index error flagged on a data word");

    a_led_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (COUNT_W'(r_led) < r_cnt))
        else $error("LED pointer beyond the frame's LED count");
endmodule
